/* rtl/core/bole_pkg.sv */
// ============================================================================
// bole_pkg: shared types and constants of the bounded ordered list engine
// Command and status codes, request and result payloads, the memory request
// that the sequencer hands to the entry store, and the ring index helpers.
// ============================================================================
package bole_pkg;

    // Most entries the store can hold.
    localparam int MAX_ENTRIES = 16;

    // Fixed field widths.
    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 5;
    localparam int COUNT_W  = 5;

    // Derived storage widths.
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_REMOVE     = 3'd4
    } cmd_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] removed_value;
        logic [COUNT_W-1:0]        entry_count;
        logic                      is_empty;
        logic signed [VALUE_W-1:0] head_value;
        logic signed [VALUE_W-1:0] tail_value;
    } res_t;

    typedef struct packed {
        logic               wr_en;
        idx_t               wr_addr;
        logic [VALUE_W-1:0] wr_data;
        idx_t               rd_addr;
    } ram_req_t;

    // Physical slot of logical position off in a ring that starts at base.
    function automatic idx_t ring_pos(input idx_t base, input idx_t off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(MAX_ENTRIES))
        begin
            sum = sum - (IDX_W+1)'(MAX_ENTRIES);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Slot in front of base, wrapping below zero.
    function automatic idx_t ring_dec(input idx_t base);
        idx_t res;
        if (base == '0)
        begin
            res = IDX_W'(MAX_ENTRIES - 1);
        end
        else
        begin
            res = base - 1'b1;
        end
        return res;
    endfunction

endpackage

/* rtl/core/bole_ram.sv */
// ============================================================================
// bole_ram: generic single write port, single read port memory
// One write and one read per cycle; the read data is registered.
// ============================================================================
module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/core/bole_ctrl.sv */
// ============================================================================
// bole_ctrl: command sequencer of the bounded ordered list engine
// Keeps the ring pointer and count, walks the store one slot at a time for
// search and gap closing, and gathers the status and the end values.
// ============================================================================
module bole_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  bole_pkg::cmd_t                cmd_data,
    input  logic [bole_pkg::CAP_W-1:0]    capacity,
    output logic                          idle,
    output bole_pkg::ram_req_t            mem_req,
    input  logic [bole_pkg::VALUE_W-1:0]  rd_data,
    output logic                          done,
    output bole_pkg::res_t                result,
    input  logic                          take
);
    import bole_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_POP_WAIT  = 10'b0000000010,
        S_SCAN      = 10'b0000000100,
        S_SCAN_CMP  = 10'b0000001000,
        S_SHIFT_RD  = 10'b0000010000,
        S_SHIFT_WR  = 10'b0000100000,
        S_FETCH_H   = 10'b0001000000,
        S_FETCH_T   = 10'b0010000000,
        S_TAIL_WAIT = 10'b0100000000,
        S_RESULT    = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;
    idx_t               head_reg, head_next;
    cnt_t               count_reg, count_next;
    idx_t               idx_reg, idx_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    status_t            status_reg, status_next;
    logic [VALUE_W-1:0] removed_reg, removed_next;
    logic [VALUE_W-1:0] head_val_reg, head_val_next;
    logic [VALUE_W-1:0] tail_val_reg, tail_val_next;

    logic [CMP_W-1:0] cap_eff;
    logic             is_full;
    logic             is_none;
    idx_t             tail_pos;
    logic             last_scan;
    logic             last_shift;

    // A capacity above the store size saturates at the store size.
    always_comb
    begin
        if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES))
        begin
            cap_eff = CMP_W'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = CMP_W'(capacity);
        end
    end

    assign is_full    = CMP_W'(count_reg) >= cap_eff;
    assign is_none    = count_reg == '0;
    assign tail_pos   = ring_pos(head_reg, IDX_W'(count_reg - 1'b1));
    assign last_scan  = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign last_shift = (CNT_W'(idx_reg) + CNT_W'(2)) == count_reg;

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        removed_next  = removed_reg;
        head_val_next = head_val_reg;
        tail_val_next = tail_val_reg;
        mem_req       = '{wr_en: 1'b0, wr_addr: head_reg, wr_data: val_reg,
                          rd_addr: head_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    val_next     = cmd_data.value;
                    status_next  = ST_OK;
                    removed_next = '0;
                    idx_next     = '0;
                    state_next   = S_FETCH_H;
                    unique case (cmd_data.command)
                        CMD_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = ring_dec(head_reg);
                                mem_req.wr_data = cmd_data.value;
                                head_next       = ring_dec(head_reg);
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        CMD_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = ring_pos(head_reg, IDX_W'(count_reg));
                                mem_req.wr_data = cmd_data.value;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (is_none)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_req.rd_addr = head_reg;
                                head_next       = ring_pos(head_reg, IDX_W'(1));
                                count_next      = count_reg - 1'b1;
                                state_next      = S_POP_WAIT;
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (is_none)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_req.rd_addr = tail_pos;
                                count_next      = count_reg - 1'b1;
                                state_next      = S_POP_WAIT;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (is_none)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // Unused codes only report the current state.
                        end
                    endcase
                end
            end
            S_POP_WAIT:
            begin
                removed_next = rd_data;
                state_next   = S_FETCH_H;
            end
            S_SCAN:
            begin
                mem_req.rd_addr = ring_pos(head_reg, idx_reg);
                state_next      = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (rd_data == val_reg)
                begin
                    removed_next = rd_data;
                    if (last_scan)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_FETCH_H;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
                else if (last_scan)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FETCH_H;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SHIFT_RD:
            begin
                mem_req.rd_addr = ring_pos(head_reg, idx_reg + 1'b1);
                state_next      = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ring_pos(head_reg, idx_reg);
                mem_req.wr_data = rd_data;
                if (last_shift)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_FETCH_H;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SHIFT_RD;
                end
            end
            S_FETCH_H:
            begin
                if (is_none)
                begin
                    head_val_next = '0;
                    tail_val_next = '0;
                    state_next    = S_RESULT;
                end
                else
                begin
                    mem_req.rd_addr = head_reg;
                    state_next      = S_FETCH_T;
                end
            end
            S_FETCH_T:
            begin
                head_val_next   = rd_data;
                mem_req.rd_addr = tail_pos;
                state_next      = S_TAIL_WAIT;
            end
            S_TAIL_WAIT:
            begin
                tail_val_next = rd_data;
                state_next    = S_RESULT;
            end
            S_RESULT:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        status_reg   <= status_next;
        removed_reg  <= removed_next;
        head_val_reg <= head_val_next;
        tail_val_reg <= tail_val_next;
    end

    assign idle = state_reg == S_IDLE;
    assign done = state_reg == S_RESULT;

    assign result = '{status:        status_reg,
                      removed_value: removed_reg,
                      entry_count:   COUNT_W'(count_reg),
                      is_empty:      is_none,
                      head_value:    head_val_reg,
                      tail_value:    tail_val_reg};

    // The count never goes past the store size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(MAX_ENTRIES))
        else $error("entry count exceeds store size");

    // One command moves the count by at most one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1 ||
             count_reg == $past(count_reg) - 1'b1))
        else $error("entry count jumped");

    // The search never looks past the last entry.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("search index beyond count");

    // Closing a gap only happens with a later entry to move.
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_RD) |-> (count_reg >= CNT_W'(2)))
        else $error("gap closing with too few entries");

    // A finished result holds until the output stage takes it.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !take) |=> (done && $stable(result)))
        else $error("result dropped before it was taken");

endmodule

/* rtl/core/bounded_ordered_list_engine_core.sv */
// ============================================================================
// bounded_ordered_list_engine_core: bounded deque with delete by value
// Ordered store of signed 32-bit values with push and pop at both ends and
// removal of the first matching entry; one result per request.
// ============================================================================
//
// Usage:
//   A request (command, value) enters on cmd_valid/cmd_stall; its result
//   (status, removed value, count, empty flag, head and tail values) leaves
//   on res_valid/res_stall. cfg_write with cfg_data sets the capacity and is
//   meant to be used only while no request is in flight.
//   Requests are handled one at a time: cmd_stall stays high from acceptance
//   until the result moves into the output register. The store is a ring
//   in one RAM with one read and one write port, and a small sequencer steps
//   through it. A push or unused code then reads the head and tail values;
//   a pop first reads the entry that it takes out. A remove reads and
//   compares each entry up to the match, then closes the gap by moving each
//   later entry one slot nearer the head. A list left empty skips the head
//   and tail reads. The sequencer uses the one RAM read port at most once
//   per step. The next request can be taken in the same cycle in which
//   res_valid rises. With res_stall high the output register holds its
//   result, the sequencer keeps the next one, and further requests stall.
//   Reset empties the list and sets the capacity to the full store size;
//   there is no clearing pass, since only live entries are ever read.
//
module bounded_ordered_list_engine_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  bole_pkg::cmd_t             cmd_data,
    output logic                       res_valid,
    input  logic                       res_stall,
    output bole_pkg::res_t             res_data,
    input  logic                       cfg_write,
    input  logic [bole_pkg::CAP_W-1:0] cfg_data
);
    import bole_pkg::*;

    logic [CAP_W-1:0]   cap_reg;
    logic               res_valid_reg, res_valid_next;
    res_t               res_data_reg;
    logic               seq_idle;
    logic               seq_done;
    logic               seq_take;
    res_t               seq_result;
    ram_req_t           mem_req;
    logic [VALUE_W-1:0] mem_rd_data;

    // Capacity register; the user must write it only between requests, the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(16);
        end
        else if (cfg_write)
        begin
            cap_reg <= cfg_data;
        end
    end

    bole_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data)
    );

    bole_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_data  (cmd_data),
        .capacity  (cap_reg),
        .idle      (seq_idle),
        .mem_req   (mem_req),
        .rd_data   (mem_rd_data),
        .done      (seq_done),
        .result    (seq_result),
        .take      (seq_take)
    );

    // The sequencer hands over its result whenever the output register is
    // empty or being emptied in this same cycle.
    assign seq_take = seq_done && (!res_valid_reg || !res_stall);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (seq_take)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_take)
        begin
            res_data_reg <= seq_result;
        end
    end

    assign cmd_stall = !seq_idle;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule
